FILE: design/bba_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes, port widths and width helpers of the buddy block allocator.
package bba_pkg;

	localparam int POOL_UNITS_DEF  = 256;
	localparam int OWNER_SLOTS_DEF = 16;

	localparam int TOTAL_W     = 9;
	localparam int ID_W        = 4;
	localparam int SIZE_W      = 9;
	localparam int STATUS_W    = 3;
	localparam int START_W     = 8;
	localparam int ORDER_OUT_W = 4;

	localparam logic OP_RESERVE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_HELD    = 3'd1,
		ST_ZERO    = 3'd2,
		ST_NOFIT   = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef struct packed {
		logic wr;
		logic val;
		logic init;
	} fm_cmd_t;

	typedef struct packed {
		logic wr;
		logic val;
		logic clr;
	} ot_cmd_t;

	function automatic int pos_width(input int pool);
		return $clog2(pool);
	endfunction

	function automatic int ord_width(input int pool);
		int w;
		w = $clog2($clog2(pool) + 2);
		return (w > ORDER_OUT_W) ? w : ORDER_OUT_W;
	endfunction

	function automatic int own_index_width(input int slots);
		int n;
		n = (slots < (1 << ID_W)) ? slots : (1 << ID_W);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int reset_total(input int pool);
		return (pool < 256) ? pool : 256;
	endfunction

endpackage

FILE: design/bba_first_set.sv
`timescale 1ns / 1ps
// Shared lowest-set-bit finder used for both steps of the free block search.
module bba_first_set #(
	parameter int IDX_W = 4
) (
	input  logic [(1 << IDX_W)-1:0] vec,
	output logic [IDX_W-1:0]        idx
);

	always_comb begin
		idx = '0;
		for (int i = (1 << IDX_W) - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

endmodule

FILE: design/bba_free_map.sv
`timescale 1ns / 1ps
// Free bit map per order level with per-level free block counters.
module bba_free_map import bba_pkg::*; #(
	parameter int POOL_UNITS = POOL_UNITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  fm_cmd_t                                   cmd,
	input  logic [TOTAL_W-1:0]                        init_total,
	input  logic [$clog2(pos_width(POOL_UNITS)+1)-1:0] lvl,
	input  logic [pos_width(POOL_UNITS)-1:0]          pos,
	output logic [POOL_UNITS-1:0]                     row,
	output logic [pos_width(POOL_UNITS):0]            nonempty
);

	localparam int POS_W = pos_width(POOL_UNITS);
	localparam int NLEV  = POS_W + 1;
	localparam int CNT_W = POS_W + 1;
	localparam logic [TOTAL_W-1:0] RESET_TOTAL = TOTAL_W'(reset_total(POOL_UNITS));

	logic [POOL_UNITS-1:0] free_q [NLEV];
	logic [CNT_W-1:0]      cnt_q  [NLEV];
	logic                  old_bit;
	logic                  pos_ok;

	function automatic logic [POOL_UNITS-1:0] init_row(input logic [TOTAL_W-1:0] tot,
		input int b);
		logic [31:0]           p;
		logic [POOL_UNITS-1:0] r;
		r = '0;
		if (b < TOTAL_W) begin
			p = (32'(tot) >> (b + 1)) << (b + 1);
			if (tot[b] && (p < POOL_UNITS)) begin
				r[p[POS_W-1:0]] = 1'b1;
			end
		end
		return r;
	endfunction

	assign row     = free_q[lvl];
	assign old_bit = free_q[lvl][pos];
	assign pos_ok  = 32'(pos) < POOL_UNITS;

	always_comb begin
		for (int b = 0; b < NLEV; b++) begin
			nonempty[b] = cnt_q[b] != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NLEV; b++) begin
				free_q[b] <= init_row(RESET_TOTAL, b);
				cnt_q[b]  <= CNT_W'(|init_row(RESET_TOTAL, b));
			end
		end else if (cmd.init) begin
			for (int b = 0; b < NLEV; b++) begin
				free_q[b] <= init_row(init_total, b);
				cnt_q[b]  <= CNT_W'(|init_row(init_total, b));
			end
		end else if (cmd.wr && pos_ok) begin
			free_q[lvl][pos] <= cmd.val;
			if (cmd.val && !old_bit) begin
				cnt_q[lvl] <= cnt_q[lvl] + CNT_W'(1);
			end else if (!cmd.val && old_bit) begin
				cnt_q[lvl] <= cnt_q[lvl] - CNT_W'(1);
			end
		end
	end

endmodule

FILE: design/bba_owner_table.sv
`timescale 1ns / 1ps
// Owner table holding the start and order of the block each owner id holds.
module bba_owner_table import bba_pkg::*; #(
	parameter int POOL_UNITS  = POOL_UNITS_DEF,
	parameter int OWNER_SLOTS = OWNER_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ot_cmd_t                              cmd,
	input  logic [own_index_width(OWNER_SLOTS)-1:0] idx,
	input  logic [pos_width(POOL_UNITS)-1:0]     wr_start,
	input  logic [ord_width(POOL_UNITS)-1:0]     wr_order,
	output logic                                 rd_valid,
	output logic [pos_width(POOL_UNITS)-1:0]     rd_start,
	output logic [ord_width(POOL_UNITS)-1:0]     rd_order
);

	localparam int POS_W = pos_width(POOL_UNITS);
	localparam int ORD_W = ord_width(POOL_UNITS);
	localparam int DEPTH = 1 << own_index_width(OWNER_SLOTS);

	logic [DEPTH-1:0] valid_q;
	logic [POS_W-1:0] start_q [DEPTH];
	logic [ORD_W-1:0] order_q [DEPTH];

	assign rd_valid = valid_q[idx];
	assign rd_start = start_q[idx];
	assign rd_order = order_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clr) begin
			valid_q <= '0;
		end else if (cmd.wr) begin
			valid_q[idx] <= cmd.val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && cmd.val) begin
			start_q[idx] <= wr_start;
			order_q[idx] <= wr_order;
		end
	end

endmodule

FILE: design/buddy_block_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the buddy block allocator: request sequencer and result registers.
//
// A request is taken when start is high and busy is low; its result appears on status,
// block_start and block_order for exactly one cycle with done high, and must be taken
// then. A request that fails its checks keeps busy high for one cycle and answers in the
// cycle after that, when busy is already low again. A reserve that succeeds stays busy
// through the check, flag, group, bit and claim states, one split state per halving from
// the order found down to the order needed and a finish state, and answers in the cycle
// after the last busy one. The free block search takes two passes of one shared 16-bit
// first-set finder (first over groups of the selected level, then within the chosen
// group), and the split then frees one upper half per cycle. A release shows its result
// during its first merge state, while busy is still high, and stays busy through its merge
// states, one buddy check per cycle, the last of which frees the merged block. A write of
// cfg_data takes effect at the clock edge that accepts it and needs no clearing pass;
// cfg_ready is high only when no request is in progress.
module buddy_block_allocator_core import bba_pkg::*; #(
	parameter int POOL_UNITS  = POOL_UNITS_DEF,
	parameter int OWNER_SLOTS = OWNER_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [TOTAL_W-1:0]     cfg_data,
	input  logic                   start,
	output logic                   busy,
	input  logic                   opcode,
	input  logic [ID_W-1:0]        owner_id,
	input  logic [SIZE_W-1:0]      request_size,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [START_W-1:0]     block_start,
	output logic [ORDER_OUT_W-1:0] block_order
);

	localparam int POS_W  = pos_width(POOL_UNITS);
	localparam int NLEV   = POS_W + 1;
	localparam int LVL_W  = $clog2(NLEV);
	localparam int ORD_W  = ord_width(POOL_UNITS);
	localparam int CHK_W  = (POS_W + 1) / 2;
	localparam int NCH_W  = POS_W - CHK_W;
	localparam int NCH    = 1 << NCH_W;
	localparam int FW     = 1 << CHK_W;
	localparam int CI_W   = (NCH_W > 0) ? NCH_W : 1;
	localparam int PAD_W  = 1 << POS_W;
	localparam int OWN_IW = own_index_width(OWNER_SLOTS);
	localparam logic [TOTAL_W-1:0] RESET_TOTAL = TOTAL_W'(reset_total(POOL_UNITS));

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FLAGS,
		S_CHUNK,
		S_BIT,
		S_CLAIM,
		S_SPLIT,
		S_FINISH,
		S_MERGE
	} state_t;

	state_t                 state_q;
	logic                   op_q;
	logic [ID_W-1:0]        id_q;
	logic [SIZE_W-1:0]      size_q;
	logic [ORD_W-1:0]       need_q;
	logic [ORD_W-1:0]       lvl_q;
	logic [ORD_W-1:0]       top_q;
	logic [POS_W-1:0]       start_q;
	logic [NCH-1:0]         flags_q;
	logic [CI_W-1:0]        chunk_q;
	logic                   done_q;
	status_t                status_q;
	logic [START_W-1:0]     bstart_q;
	logic [ORDER_OUT_W-1:0] border_q;

	logic                   cfg_take;
	logic                   req_take;
	logic [TOTAL_W-1:0]     cfg_sat;
	logic [ORD_W-1:0]       need_c;
	logic [ORD_W-1:0]       pick_lvl;
	logic                   pick_ok;
	logic                   id_ok;
	logic [OWN_IW-1:0]      own_idx;
	logic                   own_valid;
	logic [POS_W-1:0]       own_start;
	logic [ORD_W-1:0]       own_order;
	ot_cmd_t                ot_cmd;
	fm_cmd_t                fm_cmd;
	logic [ORD_W-1:0]       fm_lvl_full;
	logic [POS_W-1:0]       fm_pos;
	logic [POOL_UNITS-1:0]  row;
	logic [NLEV-1:0]        nonempty;
	logic [PAD_W-1:0]       row_pad;
	logic [NCH-1:0]         flags_c;
	logic [FW-1:0]          fs_vec;
	logic [CHK_W-1:0]       fs_idx;
	logic [POS_W-1:0]       bit_lvl;
	logic [POS_W-1:0]       bit_split;
	logic [POS_W-1:0]       buddy;
	logic                   buddy_free;
	logic                   merge_step;

	function automatic logic [3:0] clog2_size(input logic [SIZE_W-1:0] v);
		logic [3:0] t;
		t = '0;
		for (int i = 0; i <= SIZE_W; i++) begin
			if ((32'd1 << i) < 32'(v)) begin
				t = 4'(i + 1);
			end
		end
		return t;
	endfunction

	assign cfg_ready = state_q == S_IDLE;
	assign busy      = (state_q != S_IDLE) || cfg_valid;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign req_take  = start && !busy;
	assign cfg_sat   = (32'(cfg_data) > POOL_UNITS) ? TOTAL_W'(POOL_UNITS) : cfg_data;

	assign need_c  = ORD_W'(clog2_size(size_q));
	assign id_ok   = 32'(id_q) < OWNER_SLOTS;
	assign own_idx = id_q[OWN_IW-1:0];

	always_comb begin
		pick_lvl = '0;
		pick_ok  = 1'b0;
		for (int p = NLEV - 1; p >= 0; p--) begin
			if (nonempty[p] && (ORD_W'(p) >= need_c) && (ORD_W'(p) <= top_q)) begin
				pick_lvl = ORD_W'(p);
				pick_ok  = 1'b1;
			end
		end
	end

	assign row_pad = PAD_W'(row);

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			flags_c[c] = |row_pad[c*FW +: FW];
		end
	end

	assign fs_vec = (state_q == S_CHUNK) ? FW'(flags_q)
		: row_pad[(32'(chunk_q) << CHK_W) +: FW];

	bba_first_set #(
		.IDX_W(CHK_W)
	) u_first_set (
		.vec(fs_vec),
		.idx(fs_idx)
	);

	assign bit_lvl    = POS_W'(1) << lvl_q;
	assign bit_split  = POS_W'(1) << (lvl_q - ORD_W'(1));
	assign buddy      = start_q ^ bit_lvl;
	assign buddy_free = (32'(buddy) < POOL_UNITS) && row[buddy];
	assign merge_step = (lvl_q < top_q) && buddy_free;

	always_comb begin
		fm_cmd      = '0;
		fm_cmd.init = cfg_take;
		fm_lvl_full = lvl_q;
		fm_pos      = start_q;
		case (state_q)
			S_CLAIM: begin
				fm_cmd.wr = 1'b1;
			end
			S_SPLIT: begin
				fm_cmd.wr   = 1'b1;
				fm_cmd.val  = 1'b1;
				fm_lvl_full = lvl_q - ORD_W'(1);
				fm_pos      = start_q | bit_split;
			end
			S_MERGE: begin
				fm_cmd.wr = 1'b1;
				if (merge_step) begin
					fm_pos = buddy;
				end else begin
					fm_cmd.val = 1'b1;
				end
			end
			default: begin
				fm_cmd.wr = 1'b0;
			end
		endcase
	end

	bba_free_map #(
		.POOL_UNITS(POOL_UNITS)
	) u_free_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (fm_cmd),
		.init_total(cfg_sat),
		.lvl       (fm_lvl_full[LVL_W-1:0]),
		.pos       (fm_pos),
		.row       (row),
		.nonempty  (nonempty)
	);

	always_comb begin
		ot_cmd     = '0;
		ot_cmd.clr = cfg_take;
		if (state_q == S_FINISH) begin
			ot_cmd.wr  = 1'b1;
			ot_cmd.val = 1'b1;
		end else if (state_q == S_CHECK && op_q == OP_RELEASE && id_ok && own_valid) begin
			ot_cmd.wr = 1'b1;
		end
	end

	bba_owner_table #(
		.POOL_UNITS (POOL_UNITS),
		.OWNER_SLOTS(OWNER_SLOTS)
	) u_owner_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ot_cmd),
		.idx     (own_idx),
		.wr_start(start_q),
		.wr_order(need_q),
		.rd_valid(own_valid),
		.rd_start(own_start),
		.rd_order(own_order)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			top_q    <= ORD_W'(clog2_size(SIZE_W'(RESET_TOTAL)));
			done_q   <= 1'b0;
			status_q <= ST_OK;
			bstart_q <= '0;
			border_q <= '0;
			op_q     <= OP_RESERVE;
			id_q     <= '0;
			size_q   <= '0;
			need_q   <= '0;
			lvl_q    <= '0;
			start_q  <= '0;
			flags_q  <= '0;
			chunk_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_take) begin
						top_q <= ORD_W'(clog2_size(SIZE_W'(cfg_sat)));
					end else if (req_take) begin
						op_q    <= opcode;
						id_q    <= owner_id;
						size_q  <= request_size;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q  <= S_IDLE;
					bstart_q <= '0;
					border_q <= '0;
					if (!id_ok) begin
						done_q   <= 1'b1;
						status_q <= ST_UNKNOWN;
					end else if (op_q == OP_RESERVE) begin
						if (own_valid) begin
							done_q   <= 1'b1;
							status_q <= ST_HELD;
						end else if (size_q == '0) begin
							done_q   <= 1'b1;
							status_q <= ST_ZERO;
						end else if ((need_c > top_q) || !pick_ok) begin
							done_q   <= 1'b1;
							status_q <= ST_NOFIT;
						end else begin
							need_q  <= need_c;
							lvl_q   <= pick_lvl;
							state_q <= S_FLAGS;
						end
					end else if (!own_valid) begin
						done_q   <= 1'b1;
						status_q <= ST_UNKNOWN;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						bstart_q <= START_W'(own_start);
						border_q <= ORDER_OUT_W'(own_order);
						start_q  <= own_start;
						lvl_q    <= own_order;
						state_q  <= S_MERGE;
					end
				end
				S_FLAGS: begin
					flags_q <= flags_c;
					state_q <= S_CHUNK;
				end
				S_CHUNK: begin
					chunk_q <= CI_W'(fs_idx);
					state_q <= S_BIT;
				end
				S_BIT: begin
					start_q <= POS_W'((32'(chunk_q) << CHK_W) | 32'(fs_idx));
					state_q <= S_CLAIM;
				end
				S_CLAIM: begin
					state_q <= (lvl_q > need_q) ? S_SPLIT : S_FINISH;
				end
				S_SPLIT: begin
					lvl_q <= lvl_q - ORD_W'(1);
					if (lvl_q - ORD_W'(1) == need_q) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					bstart_q <= START_W'(start_q);
					border_q <= ORDER_OUT_W'(need_q);
					state_q  <= S_IDLE;
				end
				S_MERGE: begin
					if (merge_step) begin
						start_q <= start_q & ~bit_lvl;
						lvl_q   <= lvl_q + ORD_W'(1);
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign block_start = bstart_q;
	assign block_order = border_q;

endmodule

FILE: design/bba_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the buddy block allocator and its bind to the top level.
module bba_checker import bba_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [STATUS_W-1:0]    status,
	input logic [START_W-1:0]     block_start,
	input logic [ORDER_OUT_W-1:0] block_order
);

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("Result shown without a request in progress.");

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("Result strobe held for more than one cycle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (block_start == '0 && block_order == '0))
		else $error("Failed request returned a nonzero block.");

	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("Accepted request did not raise busy.");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.block_start(block_start),
	.block_order(block_order)
);

FILE: test/buddy_block_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the buddy block allocator: directed and random requests against a predictor.
module buddy_block_allocator_core_tb;
	import bba_pkg::*;

	localparam int POOL = POOL_UNITS_DEF;
	localparam int SLOTS = OWNER_SLOTS_DEF;
	localparam int ORDER_LEVELS = 17;

	typedef struct {
		status_t st;
		logic [START_W-1:0] base;
		logic [ORDER_OUT_W-1:0] ord;
	} alloc_result_t;

	class alloc_scoreboard;
		bit [POOL-1:0] free_bits [ORDER_LEVELS];
		bit held [SLOTS];
		int held_start [SLOTS];
		int held_order [SLOTS];
		int pool_size;
		int top_order;
		int errors;
		alloc_result_t pending [$];

		function new();
			errors = 0;
			load_pool(POOL);
		endfunction

		function int order_for(int v);
			int t;
			t = 0;
			while (t < ORDER_LEVELS - 1 && (1 << t) < v)
				t++;
			return t;
		endfunction

		// Splits the pool by its binary decomposition, largest block at unit 0.
		function void load_pool(int v);
			int pos;
			if (v > POOL)
				v = POOL;
			pool_size = v;
			top_order = order_for(v);
			for (int b = 0; b < ORDER_LEVELS; b++)
				free_bits[b] = '0;
			for (int i = 0; i < SLOTS; i++) begin
				held[i] = 0;
				held_start[i] = 0;
				held_order[i] = 0;
			end
			pos = 0;
			for (int b = ORDER_LEVELS - 1; b >= 0; b--) begin
				if ((pool_size >> b) & 1) begin
					if (pos < POOL)
						free_bits[b][pos] = 1'b1;
					pos += 1 << b;
				end
			end
		endfunction

		function void note_request(bit op, int id, int size);
			alloc_result_t r;
			int need;
			int lvl;
			int base;
			int buddy;
			bit found;
			r.st = ST_OK;
			r.base = '0;
			r.ord = '0;
			if (op == OP_RESERVE) begin
				if (held[id]) begin
					r.st = ST_HELD;
				end else if (size == 0) begin
					r.st = ST_ZERO;
				end else begin
					need = order_for(size);
					found = 0;
					base = 0;
					lvl = need;
					while (lvl <= top_order && !found) begin
						for (int u = 0; u < POOL; u++) begin
							if (!found && free_bits[lvl][u]) begin
								base = u;
								found = 1;
							end
						end
						if (!found)
							lvl++;
					end
					if (need > top_order || !found) begin
						r.st = ST_NOFIT;
					end else begin
						free_bits[lvl][base] = 1'b0;
						while (lvl > need) begin
							lvl--;
							if (base + (1 << lvl) < POOL)
								free_bits[lvl][base + (1 << lvl)] = 1'b1;
						end
						held[id] = 1;
						held_start[id] = base;
						held_order[id] = need;
						r.base = base[START_W-1:0];
						r.ord = need[ORDER_OUT_W-1:0];
					end
				end
			end else begin
				if (!held[id]) begin
					r.st = ST_UNKNOWN;
				end else begin
					base = held_start[id];
					lvl = held_order[id];
					held[id] = 0;
					r.base = base[START_W-1:0];
					r.ord = lvl[ORDER_OUT_W-1:0];
					found = 1;
					while (lvl < top_order && found) begin
						buddy = base ^ (1 << lvl);
						if (buddy < POOL && free_bits[lvl][buddy]) begin
							free_bits[lvl][buddy] = 1'b0;
							base = base & ~(1 << lvl);
							lvl++;
						end else begin
							found = 0;
						end
					end
					if (base < POOL)
						free_bits[lvl][base] = 1'b1;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [START_W-1:0] base,
				logic [ORDER_OUT_W-1:0] ord);
			alloc_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with no request pending: status %0d start %0d order %0d",
					$time, st, base, ord);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (base !== e.base) begin
				$display("%0t: block_start expected %0d actual %0d", $time, e.base, base);
				errors++;
			end
			if (ord !== e.ord) begin
				$display("%0t: block_order expected %0d actual %0d", $time, e.ord, ord);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [TOTAL_W-1:0] cfg_data;
	logic start;
	logic busy;
	logic opcode;
	logic [ID_W-1:0] owner_id;
	logic [SIZE_W-1:0] request_size;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [START_W-1:0] block_start;
	logic [ORDER_OUT_W-1:0] block_order;

	alloc_scoreboard sb;

	buddy_block_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.owner_id(owner_id),
		.request_size(request_size),
		.done(done),
		.status(status),
		.block_start(block_start),
		.block_order(block_order)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, block_start, block_order);
	end

	task automatic idle_gap(input int pct);
		while ($urandom_range(99) < pct)
			@(negedge clk);
	endtask

	task automatic issue_request(input bit op, input int id, input int size);
		opcode = op;
		owner_id = id[ID_W-1:0];
		request_size = size[SIZE_W-1:0];
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(op, id, size);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic write_pool_size(input int v);
		wait_drained();
		cfg_data = v[TOTAL_W-1:0];
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.load_pool(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_size(int pool);
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(8, 1);
		if (r < 85)
			return $urandom_range(32, 1);
		if (r < 95)
			return $urandom_range((pool > 1) ? pool : 1, 1);
		return $urandom_range(511);
	endfunction

	// Mostly well-formed reserve/release traffic per owner, with some malformed requests mixed in.
	task automatic run_random(input int count, input int pct);
		int id;
		repeat (count) begin
			idle_gap(pct);
			id = $urandom_range(SLOTS - 1);
			if ($urandom_range(99) < 8)
				issue_request(1'($urandom_range(1)), id, $urandom_range(511));
			else if (sb.held[id] && $urandom_range(99) < 75)
				issue_request(OP_RELEASE, id, $urandom_range(511));
			else
				issue_request(OP_RESERVE, id, pick_size(sb.pool_size));
		end
	endtask

	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int pools [6];
		int pcts [6];
		int wait_cycles;
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		opcode = OP_RESERVE;
		owner_id = '0;
		request_size = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		issue_request(OP_RESERVE, 0, 0);
		issue_request(OP_RESERVE, 0, 1);
		issue_request(OP_RESERVE, 0, 5);
		issue_request(OP_RESERVE, 1, 256);
		issue_request(OP_RESERVE, 2, 511);
		issue_request(OP_RELEASE, 3, 0);
		issue_request(OP_RESERVE, 1, 3);
		issue_request(OP_RESERVE, 2, 128);
		issue_request(OP_RELEASE, 0, 511);
		issue_request(OP_RELEASE, 1, 0);
		issue_request(OP_RELEASE, 2, 0);
		issue_request(OP_RESERVE, 15, 256);
		issue_request(OP_RELEASE, 15, 0);
		write_pool_size(0);
		issue_request(OP_RESERVE, 5, 1);
		issue_request(OP_RELEASE, 5, 0);
		write_pool_size(13);
		issue_request(OP_RESERVE, 4, 4);
		issue_request(OP_RESERVE, 6, 1);
		issue_request(OP_RESERVE, 7, 1);
		issue_request(OP_RESERVE, 8, 16);
		issue_request(OP_RELEASE, 7, 0);
		write_pool_size(1);
		issue_request(OP_RESERVE, 9, 1);
		issue_request(OP_RESERVE, 10, 2);

		pools = '{256, 37, 511, 255, 2, 0};
		pcts = '{0, 53, 28, 0, 53, 28};
		pools[5] = $urandom_range(256, 1);
		foreach (pools[i]) begin
			write_pool_size(pools[i]);
			run_random(205, pcts[i]);
		end

		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < 400) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (24) @(negedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
